/* hw/rtl/sird_pkg.sv */
// shared types and constants for the signed integer to radix digits converter
package sird_pkg;

    localparam int ALPHA_BYTES = 32;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 5;
    localparam int LEN_W       = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int DIV_RADIX_BITS = 8;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
    localparam logic [LEN_W-1:0]  MIN_BASE   = 6'd2;

    typedef logic [ALPHA_BYTES-1:0][CHAR_W-1:0] t_alpha_bytes;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ALPHA_WORD0 = 2'd0,
        CFG_ALPHA_WORD1 = 2'd1,
        CFG_ALPHA_WORD2 = 2'd2,
        CFG_ALPHA_WORD3 = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic done;
        logic bad;
    } t_chk_status;

endpackage

/* hw/rtl/sird_ram.sv */
// generic single write port memory with registered read
module sird_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/sird_alpha_check.sv */
// alphabet length and validity check, one alphabet position per cycle
module sird_alpha_check import sird_pkg::*; #(
    parameter int MAX_BASE = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  t_alpha_bytes i_alpha,
    output logic [LEN_W-1:0] o_len,
    output t_chk_status  o_status
);

    logic [LEN_W-1:0]   len;
    logic [DIGIT_W-1:0] r_idx;
    logic               r_busy;
    logic               r_done;
    logic               r_bad;
    logic [CHAR_W-1:0]  cur;
    logic               hit;
    logic               at_end;

    // length: first zero byte among the first MAX_BASE bytes
    always_comb begin
        len = LEN_W'(MAX_BASE);
        for (int n = MAX_BASE - 1; n >= 0; n--) begin
            if (i_alpha[n] == CHAR_NONE) begin
                len = LEN_W'(n);
            end
        end
    end

    // current character against signs and every later character
    always_comb begin
        cur = i_alpha[r_idx];
        hit = (cur == CHAR_PLUS) || (cur == CHAR_MINUS);
        for (int j = 0; j < ALPHA_BYTES; j++) begin
            if ((LEN_W'(j) > {1'b0, r_idx}) && (LEN_W'(j) < len) && (i_alpha[j] == cur)) begin
                hit = 1'b1;
            end
        end
    end

    assign at_end = (({1'b0, r_idx} + 1'b1) == len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bad  <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (len < MIN_BASE || hit) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_bad  <= 1'b1;
                end else if (at_end) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_bad  <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_len           = len;
    assign o_status.done   = r_done;
    assign o_status.bad    = r_bad;

endmodule

/* hw/rtl/sird_divider.sv */
// iterative divider by a small radix, eight quotient bits per cycle
module sird_divider import sird_pkg::*; #(
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [LEN_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient,
    output logic [DIGIT_W-1:0] o_remainder
);

    localparam int STEPS = (DATA_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int PAD_W = STEPS * DIV_RADIX_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0]   r_q;
    logic [DIGIT_W-1:0] r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [PAD_W-1:0]   n_q;
    logic [DIGIT_W-1:0] n_rem;

    // radix-256 step: eight restoring steps on a remainder below the divisor
    always_comb begin
        logic [LEN_W-1:0] t;
        n_q   = r_q;
        n_rem = r_rem;
        for (int k = 0; k < DIV_RADIX_BITS; k++) begin
            t   = {n_rem, n_q[PAD_W-1]};
            n_q = {n_q[PAD_W-2:0], 1'b0};
            if (t >= i_divisor) begin
                t      = t - i_divisor;
                n_q[0] = 1'b1;
            end
            n_rem = t[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= PAD_W'(i_dividend);
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q[DATA_W-1:0];
    assign o_remainder = r_rem;

endmodule

/* hw/rtl/signed_int_to_radix_digits.sv */
// top level: signed integer to text in a configurable radix
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------------
//  input    | in        | i_in_valid / o_in_stall | i_value
//  output   | out       | o_out_valid / i_out_stall | o_character, o_last, o_bad_alphabet
//  config   | in        | i_cfg_wr_en             | i_cfg_index, i_cfg_wdata
//
// one number at a time: the alphabet check walks one position per cycle, then each
// digit takes a pass through the shared divider, then each character goes through the
// digit memory read while the minus sign goes straight out; the worst case at the
// defaults is a two-character alphabet with the most negative value
// synchronous active-low reset clears control state and the alphabet words
// a stalled output holds its character; no new number is taken until the last
// character of the current one is transferred
module signed_int_to_radix_digits import sird_pkg::*; #(
    parameter int MAX_BASE    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_wdata,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [CHAR_W-1:0]             o_character,
    output logic                          o_last,
    output logic                          o_bad_alphabet
);

    localparam int ADDR_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_RD,
        ST_LD,
        ST_OUT
    } t_state;

    t_state r_state;

    // alphabet configuration words
    logic [CFG_DATA_W-1:0] r_alpha_word0;
    logic [CFG_DATA_W-1:0] r_alpha_word1;
    logic [CFG_DATA_W-1:0] r_alpha_word2;
    logic [CFG_DATA_W-1:0] r_alpha_word3;
    t_alpha_bytes          alpha;

    // working state
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [CNT_W-1:0]       r_count;
    logic                   r_div_start;

    // output register
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_character;
    logic              r_last;
    logic              r_bad;

    logic                   in_xfer;
    logic                   out_xfer;
    logic [VALUE_WIDTH-1:0] value_u;
    logic [VALUE_WIDTH-1:0] value_mag;

    logic [LEN_W-1:0]       alpha_len;
    t_chk_status            chk_status;

    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [DIGIT_W-1:0]     div_rem;
    logic                   digit_wr;
    logic                   more_digits;
    logic [DIGIT_W-1:0]     rd_digit;
    logic [ADDR_W-1:0]      rd_addr;

    assign alpha = t_alpha_bytes'({r_alpha_word3, r_alpha_word2, r_alpha_word1, r_alpha_word0});

    // alphabet words; the host must write them only between numbers, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_word0 <= '0;
            r_alpha_word1 <= '0;
            r_alpha_word2 <= '0;
            r_alpha_word3 <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_ALPHA_WORD0: r_alpha_word0 <= i_cfg_wdata;
                CFG_ALPHA_WORD1: r_alpha_word1 <= i_cfg_wdata;
                CFG_ALPHA_WORD2: r_alpha_word2 <= i_cfg_wdata;
                CFG_ALPHA_WORD3: r_alpha_word3 <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_out_valid && !i_out_stall;

    // magnitude taken unsigned so the most negative value converts
    assign value_u   = i_value;
    assign value_mag = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;

    sird_alpha_check #(
        .MAX_BASE (MAX_BASE)
    ) u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_xfer),
        .i_alpha  (alpha),
        .o_len    (alpha_len),
        .o_status (chk_status)
    );

    sird_divider #(
        .DATA_W (VALUE_WIDTH)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_mag),
        .i_divisor   (alpha_len),
        .o_done      (div_done),
        .o_quotient  (div_quot),
        .o_remainder (div_rem)
    );

    // digits stored least significant first, read back from the top
    assign digit_wr    = (r_state == ST_DIV) && div_done;
    assign rd_addr     = ADDR_W'(r_count - 1'b1);
    assign more_digits = (div_quot != '0) && ((r_count + 1'b1) < CNT_W'(VALUE_WIDTH));

    sird_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_WIDTH)
    ) u_digits (
        .i_clk     (i_clk),
        .i_wr_en   (digit_wr),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (div_rem),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_digit)
    );

    // sequencer: check, divide loop, sign, then characters high digit first; a bad alphabet gives one error result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_count     <= '0;
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_character <= CHAR_NONE;
            r_last      <= 1'b0;
            r_bad       <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_neg   <= value_u[VALUE_WIDTH-1];
                        r_mag   <= value_mag;
                        r_count <= '0;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (chk_status.done) begin
                        if (chk_status.bad) begin
                            // single error result, nothing printed
                            r_character <= CHAR_NONE;
                            r_last      <= 1'b1;
                            r_bad       <= 1'b1;
                            r_out_valid <= 1'b1;
                            r_state     <= ST_OUT;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state     <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_mag   <= div_quot;
                        r_count <= r_count + 1'b1;
                        if (more_digits) begin
                            r_div_start <= 1'b1;
                        end else if (r_neg) begin
                            r_character <= CHAR_MINUS;
                            r_last      <= 1'b0;
                            r_bad       <= 1'b0;
                            r_out_valid <= 1'b1;
                            r_state     <= ST_OUT;
                        end else begin
                            r_state <= ST_RD;
                        end
                    end
                end
                ST_RD: begin
                    // memory read address presented this cycle
                    r_state <= ST_LD;
                end
                ST_LD: begin
                    r_character <= alpha[rd_digit];
                    r_last      <= (r_count == CNT_W'(1));
                    r_bad       <= 1'b0;
                    r_count     <= r_count - 1'b1;
                    r_out_valid <= 1'b1;
                    r_state     <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_xfer) begin
                        r_out_valid <= 1'b0;
                        r_state     <= r_last ? ST_IDLE : ST_RD;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_character    = r_character;
    assign o_last         = r_last;
    assign o_bad_alphabet = r_bad;

endmodule

/* sim/tb_top.sv */
// testbench for the signed integer to radix digits converter
`timescale 1ns / 100ps

module tb_top import sird_pkg::*; ();

    localparam int VALUE_W     = 32;
    localparam int CYCLE_LIMIT = 400000;
    // quiet cycles after the last character before touching the alphabet
    localparam int SETTLE      = 40;

    // one expected output transfer
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } t_char_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_wdata = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [CHAR_W-1:0]         o_character;
    logic                      o_last;
    logic                      o_bad_alphabet;

    // shadow of the four alphabet words, byte i of the alphabet at [8*i +: 8]
    logic [ALPHA_BYTES*CHAR_W-1:0] alpha_flat = '0;

    logic [VALUE_W-1:0] pending_values[$];
    t_char_result       expected_chars[$];

    int unsigned in_wait = 0;
    int unsigned out_wait = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    bit          no_gaps = 1'b0;

    signed_int_to_radix_digits #(
        .MAX_BASE    (32),
        .VALUE_WIDTH (VALUE_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_character    (o_character),
        .o_last         (o_last),
        .o_bad_alphabet (o_bad_alphabet)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // idle cycles after a transfer, none at all in a no-gap phase
    function automatic int unsigned draw_gap();
        if (no_gaps)
            return 0;
        return $urandom_range(0, 5);
    endfunction

    // expected text of one number under the current alphabet
    task automatic predict_text(input logic [VALUE_W-1:0] v);
        logic [CHAR_W-1:0]  c;
        logic [DIGIT_W-1:0] digits [ALPHA_BYTES];
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        int unsigned        len;
        int unsigned        n;
        bit                 ok;
        bit                 neg;

        // length stops at the first zero byte
        len = 0;
        while (len < ALPHA_BYTES && alpha_flat[len*CHAR_W +: CHAR_W] != CHAR_NONE)
            len++;

        ok = (len >= MIN_BASE);
        for (int i = 0; i < len; i++) begin
            c = alpha_flat[i*CHAR_W +: CHAR_W];
            if (c == CHAR_PLUS || c == CHAR_MINUS)
                ok = 1'b0;
            for (int j = i + 1; j < len; j++)
                if (alpha_flat[j*CHAR_W +: CHAR_W] == c)
                    ok = 1'b0;
        end

        if (!ok) begin
            expected_chars.push_back('{ch: CHAR_NONE, last: 1'b1, bad: 1'b1});
            return;
        end

        // magnitude taken unsigned so the most negative value survives
        neg   = v[VALUE_W-1];
        mag   = neg ? (VALUE_W'(0) - v) : v;
        radix = VALUE_W'(len);
        n     = 0;
        do begin
            digits[n] = DIGIT_W'(mag % radix);
            mag       = mag / radix;
            n++;
        end while (mag != 0 && n < VALUE_W);

        if (neg)
            expected_chars.push_back('{ch: CHAR_MINUS, last: 1'b0, bad: 1'b0});
        for (int i = n; i > 0; i--)
            expected_chars.push_back('{ch: alpha_flat[digits[i-1]*CHAR_W +: CHAR_W],
                                       last: (i == 1), bad: 1'b0});
    endtask

    // input driver: launches queued numbers, holds a stalled one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_wait    <= 0;
        end else begin
            // transfer on this edge: work out its text now
            if (i_in_valid && !o_in_stall)
                predict_text(i_value);

            if (i_in_valid && o_in_stall) begin
                // stalled, payload stays put
            end else if (in_wait != 0) begin
                i_in_valid <= 1'b0;
                in_wait    <= in_wait - 1;
            end else if (pending_values.size() != 0) begin
                i_in_valid <= 1'b1;
                i_value    <= pending_values.pop_front();
                in_wait    <= draw_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output monitor: random stall after each transfer, field by field check
    always @(posedge i_clk) begin
        t_char_result want;
        int unsigned  hold;

        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_wait    <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: char %h last %b bad %b",
                             o_character, o_last, o_bad_alphabet);
            end else begin
                want = expected_chars.pop_front();
                if (want.ch !== o_character || want.last !== o_last ||
                    want.bad !== o_bad_alphabet) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected char %h last %b bad %b,",
                                 want.ch, want.last, want.bad,
                                 " got char %h last %b bad %b",
                                 o_character, o_last, o_bad_alphabet);
                end
            end
            hold = draw_gap();
            out_wait    <= hold;
            i_out_stall <= (hold != 0);
        end else if (out_wait > 1) begin
            out_wait    <= out_wait - 1;
            i_out_stall <= 1'b1;
        end else begin
            out_wait    <= 0;
            i_out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_word(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        alpha_flat[idx*CFG_DATA_W +: CFG_DATA_W] = data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // all four words go out on every alphabet change
    task automatic set_alphabet(input logic [ALPHA_BYTES*CHAR_W-1:0] flat);
        write_word(CFG_ALPHA_WORD0, flat[0*CFG_DATA_W +: CFG_DATA_W]);
        write_word(CFG_ALPHA_WORD1, flat[1*CFG_DATA_W +: CFG_DATA_W]);
        write_word(CFG_ALPHA_WORD2, flat[2*CFG_DATA_W +: CFG_DATA_W]);
        write_word(CFG_ALPHA_WORD3, flat[3*CFG_DATA_W +: CFG_DATA_W]);
    endtask

    function automatic logic [ALPHA_BYTES*CHAR_W-1:0] text_alphabet(input string s);
        logic [ALPHA_BYTES*CHAR_W-1:0] flat;
        flat = '0;
        for (int i = 0; i < s.len() && i < ALPHA_BYTES; i++)
            flat[i*CHAR_W +: CHAR_W] = s[i];
        return flat;
    endfunction

    // distinct non-sign digits, garbage past the terminator; spoil breaks it
    function automatic logic [ALPHA_BYTES*CHAR_W-1:0] random_alphabet(input int unsigned n,
                                                                        input bit spoil);
        logic [ALPHA_BYTES*CHAR_W-1:0] flat;
        bit          used [256];
        int unsigned c;
        flat = {8{$urandom()}};
        for (int i = 0; i < n; i++) begin
            do
                c = $urandom_range(1, 255);
            while (used[c] || c == CHAR_PLUS || c == CHAR_MINUS);
            used[c] = 1'b1;
            flat[i*CHAR_W +: CHAR_W] = CHAR_W'(c);
        end
        if (n < ALPHA_BYTES)
            flat[n*CHAR_W +: CHAR_W] = CHAR_NONE;
        if (spoil) begin
            if ($urandom_range(0, 1) == 0)
                flat[$urandom_range(1, n - 1)*CHAR_W +: CHAR_W] = flat[CHAR_W-1:0];
            else
                flat[$urandom_range(0, n - 1)*CHAR_W +: CHAR_W] =
                    ($urandom_range(0, 1) == 0) ? CHAR_PLUS : CHAR_MINUS;
        end
        return flat;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0:       return VALUE_W'($urandom_range(0, 40));
            1:       return VALUE_W'(0) - VALUE_W'($urandom_range(1, 40));
            2:       return ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // everything accepted and checked, then let the block go quiet
    task automatic drain();
        while (pending_values.size() != 0 || i_in_valid || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_values(input logic [VALUE_W-1:0] vals[$]);
        foreach (vals[i])
            pending_values.push_back(vals[i]);
    endtask

    initial begin
        int unsigned len;
        bit          spoil;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // alphabet after reset is empty, so every number is rejected
        push_values({32'd5, 32'h8000_0000});
        drain();

        // decimal: zero, unit steps, both extremes
        set_alphabet(text_alphabet("0123456789"));
        push_values({32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'd10, -32'sd10, 32'd9});
        drain();

        // binary: the most negative value gives the longest text
        no_gaps = 1'b1;
        set_alphabet(text_alphabet("01"));
        push_values({32'h8000_0000, 32'h7FFF_FFFF, 32'd0});
        drain();

        // full 32-character alphabet with no terminating zero byte
        no_gaps = 1'b0;
        set_alphabet(text_alphabet("0123456789ABCDEFGHIJKLMNOPQRSTUV"));
        push_values({32'd31, 32'h8000_0000, 32'hFFFF_FFE0});
        drain();

        // broken alphabets: repeated digit, plus sign, minus sign, too short
        set_alphabet(text_alphabet("0120"));
        push_values({32'd7});
        drain();
        set_alphabet(text_alphabet("01+"));
        push_values({32'd7});
        drain();
        set_alphabet(text_alphabet("-01"));
        push_values({32'hFFFF_FFF9});
        drain();
        set_alphabet(text_alphabet("0"));
        push_values({32'd0});
        drain();

        // base three with high-bit characters
        set_alphabet({{29{8'h55}}, 8'h7F, 8'h80, 8'hFF} & {{232{1'b0}}, 24'hFF_FFFF});
        push_values({32'd8, 32'hFFFF_FFF8, 32'h8000_0000});
        drain();

        // random alphabets, mostly valid, with random numbers
        repeat (9) begin
            case ($urandom_range(0, 2))
                0:       len = $urandom_range(2, 4);
                1:       len = $urandom_range(5, 31);
                default: len = ALPHA_BYTES;
            endcase
            spoil   = ($urandom_range(0, 5) == 0);
            no_gaps = ($urandom_range(0, 3) == 0);
            set_alphabet(random_alphabet(len, spoil));
            repeat (12)
                pending_values.push_back(random_value());
            drain();
        end

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/sird_pkg.sv
hw/rtl/sird_ram.sv
hw/rtl/sird_alpha_check.sv
hw/rtl/sird_divider.sv
hw/rtl/signed_int_to_radix_digits.sv
sim/tb_top.sv
